@@ hdl/rtemf_pkg.sv @@
// Shared types, constants and the type R coefficient table for the
// temperature-to-EMF block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtemf_pkg;

  localparam int FRAC_BITS = 48;
  localparam int XSHIFT    = 11;
  localparam int TEMP_W    = 20;
  localparam int EMF_W     = 19;
  localparam int FIX_W     = 64;
  localparam int NCOEF     = 21;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [EMF_W-1:0]  emf_t;
  typedef logic signed [FIX_W-1:0]  fix_t;

  localparam temp_t T_LOW  = -20'sd5000;
  localparam temp_t T_HIGH = 20'sd176810;
  localparam temp_t T_SEG1 = 20'sd106418;
  localparam temp_t T_SEG2 = 20'sd166450;

  localparam fix_t FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};
  localparam fix_t EMF_MAX = 64'sd262143;
  localparam fix_t EMF_MIN = -64'sd262144;

  localparam logic [FIX_W-1:0] EMF_SCALE = 64'd10000;

  // first coefficient index and degree of each segment
  localparam logic [4:0] SEG0_FIRST = 5'd0;
  localparam logic [4:0] SEG1_FIRST = 5'd10;
  localparam logic [4:0] SEG2_FIRST = 5'd16;
  localparam logic [3:0] SEG0_DEG   = 4'd9;
  localparam logic [3:0] SEG1_DEG   = 4'd5;
  localparam logic [3:0] SEG2_DEG   = 4'd4;

  // coefficient = mant * 10^-dexp, mV per C^k
  localparam logic signed [63:0] COEF_MANT [NCOEF] = '{
    64'sd0, 64'sd528961729765, 64'sd139166589782, -64'sd238855693017,
    64'sd356916001063, -64'sd462347666298, 64'sd500777441034,
    -64'sd373105886191, 64'sd157716482367, -64'sd281038625251,
    64'sd295157925316, -64'sd252061251332, 64'sd159564501865,
    -64'sd764085947576, 64'sd205305291024, -64'sd293359668173,
    64'sd152232118209, -64'sd268819888545, 64'sd171280280471,
    -64'sd345895706453, -64'sd934633971046
  };
  localparam int COEF_DEXP [NCOEF] = '{
    12, 14, 16, 19, 22, 25, 28, 31, 34, 38,
    11, 14, 16, 20, 23, 27,
    9, 12, 15, 19, 26
  };
  localparam int COEF_POW [NCOEF] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9,
    0, 1, 2, 3, 4, 5,
    0, 1, 2, 3, 4
  };

  // round(|mant| * 2^(11k + FRAC_BITS) / 10^dexp), signed, saturated
  function automatic fix_t coef_fixed(int idx);
    logic [255:0]      w;
    logic [63:0]       m;
    logic [63:0]       q;
    logic signed [63:0] mv;
    logic              neg;
    int                d;
    mv  = COEF_MANT[idx];
    neg = mv[63];
    m   = neg ? 64'(-mv) : 64'(mv);
    w   = 256'(m) << (XSHIFT * COEF_POW[idx] + FRAC_BITS + 1);
    for (d = 0; d < COEF_DEXP[idx]; d++) begin
      w = w / 256'd10;
    end
    if (|w[255:64]) begin
      q = 64'(FIX_MAX);
    end else begin
      q = (w[63:0] >> 1) + 64'(w[0]);
      if (q[63]) begin
        q = 64'(FIX_MAX);
      end
    end
    return neg ? fix_t'(-q) : fix_t'(q);
  endfunction

  localparam fix_t COEF_TAB [NCOEF] = '{
    coef_fixed(0),  coef_fixed(1),  coef_fixed(2),  coef_fixed(3),
    coef_fixed(4),  coef_fixed(5),  coef_fixed(6),  coef_fixed(7),
    coef_fixed(8),  coef_fixed(9),  coef_fixed(10), coef_fixed(11),
    coef_fixed(12), coef_fixed(13), coef_fixed(14), coef_fixed(15),
    coef_fixed(16), coef_fixed(17), coef_fixed(18), coef_fixed(19),
    coef_fixed(20)
  };

endpackage

`default_nettype wire

@@ hdl/rtemf_if.sv @@
// Valid/ready channel interfaces for temperature samples and EMF results.
// Depends on rtemf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rtemf_in_if;
  import rtemf_pkg::*;
  logic  valid;
  logic  ready;
  temp_t temp_centi;
  modport source (output valid, output temp_centi, input ready);
  modport sink (input valid, input temp_centi, output ready);
endinterface

interface rtemf_out_if;
  import rtemf_pkg::*;
  logic valid;
  logic ready;
  emf_t emf_tenth_uv;
  logic out_of_range;
  modport source (output valid, output emf_tenth_uv, output out_of_range, input ready);
  modport sink (input valid, input emf_tenth_uv, input out_of_range, output ready);
endinterface

`default_nettype wire

@@ hdl/type_r_thermocouple_temp_to_emf.sv @@
// Type R thermocouple temperature to EMF: Horner evaluation on one shared
// 32x32 multiplier, radix-16 scaling divider. Depends on rtemf_pkg, rtemf_if.
// Steps: accept, radix-16 divide of the scaled temperature by 100, then per
// multiply-add on the shared 32x32 multiplier: operand prep, 4 partial
// products, round/add; finally load the output register.
// In-range segments split at 1064.18 C and 1664.5 C; out-of-range samples
// go straight to the output. One sample at a time; next accepted once the result
// moves to the output register. Sync active-high reset clears control state.
`timescale 1ns / 1ps
`default_nettype none

module type_r_thermocouple_temp_to_emf (
  input  logic        clk,
  input  logic        rst,
  rtemf_in_if.sink    sample,
  rtemf_out_if.source result
);
  import rtemf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam int TMAG_W     = 18;
  localparam int DIV_DIGITS = (FRAC_BITS - XSHIFT + TMAG_W + 1 + 3) / 4;
  localparam int DIV_W      = DIV_DIGITS * 4;
  localparam int DCNT_W     = $clog2(DIV_DIGITS);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_DIGITS - 1);
  localparam logic [127:0] RND = 128'd1 << (FRAC_BITS - 1);

  logic [2:0]        state;
  logic [DIV_W-1:0]  dividend;
  logic [DIV_W-1:0]  quo;
  logic [6:0]        rem;
  logic [DCNT_W-1:0] dcnt;
  logic              x_neg;
  logic [63:0]       xmag;
  fix_t              acc;
  logic [4:0]        first;
  logic [3:0]        k;
  logic              last;
  logic [63:0]       ua;
  logic [63:0]       ub;
  logic              pneg;
  logic [63:0]       pp;
  logic [1:0]        ppsel;
  logic [127:0]      prod;
  logic [2:0]        mcnt;
  emf_t              res_emf;
  logic              res_oor;
  logic              out_valid;
  emf_t              out_emf;
  logic              out_oor;

  temp_t             t;
  temp_t             tneg;
  logic              in_oor;
  logic [TMAG_W-1:0] tmag;
  logic [10:0]       v;
  logic [3:0]        dig;
  logic [10:0]       v_rem;
  logic [DIV_W-1:0]  quo_next;
  logic [31:0]       a_sel;
  logic [31:0]       b_sel;
  logic [63:0]       mul_out;
  logic [127:0]      pp_term;
  logic [4:0]        cidx;
  fix_t              addend;
  logic [63:0]       fin_mag;
  logic              fin_ovf;
  logic [63:0]       magc;
  logic [64:0]       sum;
  fix_t              sum_sat;
  emf_t              emf_clamp;

  assign t      = sample.temp_centi;
  assign tneg   = -t;
  assign in_oor = (t < T_LOW) || (t > T_HIGH);
  assign tmag   = t[TEMP_W-1] ? tneg[TMAG_W-1:0] : t[TMAG_W-1:0];

  // radix-16 digit of the divide by 100
  assign v = {rem, dividend[DIV_W-1 -: 4]};
  always_comb begin
    dig = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (v >= 11'(i * 100)) begin
        dig = 4'(i);
      end
    end
  end
  assign v_rem    = v - 11'(dig) * 11'd100;
  assign quo_next = {quo[DIV_W-5:0], dig};

  // shared multiplier, partial product order a0b0, a0b1, a1b0, a1b1
  assign a_sel   = mcnt[1] ? ua[63:32] : ua[31:0];
  assign b_sel   = mcnt[0] ? ub[63:32] : ub[31:0];
  assign mul_out = 64'(a_sel) * 64'(b_sel);

  always_comb begin
    case (ppsel)
      2'd0:    pp_term = {64'd0, pp};
      2'd3:    pp_term = {pp, 64'd0};
      default: pp_term = {32'd0, pp, 32'd0};
    endcase
  end

  // round, saturate, add coefficient
  assign cidx    = first + {1'b0, k} - 5'd1;
  assign addend  = last ? '0 : COEF_TAB[cidx];
  assign fin_mag = prod[FRAC_BITS +: 64];
  assign fin_ovf = |prod[127:FRAC_BITS+64];
  assign magc    = (fin_ovf || fin_mag[63]) ? 64'(FIX_MAX) : fin_mag;
  assign sum     = pneg ? {addend[63], addend} - {1'b0, magc}
                        : {addend[63], addend} + {1'b0, magc};

  always_comb begin
    if (sum[64] != sum[63]) begin
      sum_sat = sum[64] ? FIX_MIN : FIX_MAX;
    end else begin
      sum_sat = fix_t'(sum[63:0]);
    end
    if (sum_sat > EMF_MAX) begin
      emf_clamp = emf_t'(EMF_MAX);
    end else if (sum_sat < EMF_MIN) begin
      emf_clamp = emf_t'(EMF_MIN);
    end else begin
      emf_clamp = sum_sat[EMF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            if (in_oor) begin
              res_emf <= '0;
              res_oor <= 1'b1;
              state   <= S_DONE;
            end else begin
              x_neg    <= t[TEMP_W-1];
              dividend <= (DIV_W'(tmag) << (FRAC_BITS - XSHIFT)) + DIV_W'(50);
              rem      <= 7'd0;
              dcnt     <= '0;
              last     <= 1'b0;
              if (t < T_SEG1) begin
                first <= SEG0_FIRST;
                k     <= SEG0_DEG;
                acc   <= COEF_TAB[SEG0_FIRST + 5'(SEG0_DEG)];
              end else if (t < T_SEG2) begin
                first <= SEG1_FIRST;
                k     <= SEG1_DEG;
                acc   <= COEF_TAB[SEG1_FIRST + 5'(SEG1_DEG)];
              end else begin
                first <= SEG2_FIRST;
                k     <= SEG2_DEG;
                acc   <= COEF_TAB[SEG2_FIRST + 5'(SEG2_DEG)];
              end
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          dividend <= dividend << 4;
          rem      <= v_rem[6:0];
          quo      <= quo_next;
          dcnt     <= dcnt + 1'b1;
          if (dcnt == DCNT_LAST) begin
            xmag  <= 64'(quo_next);
            state <= S_PREP;
          end
        end
        S_PREP: begin
          ua    <= acc[63] ? 64'(-acc) : 64'(acc);
          ub    <= last ? EMF_SCALE : xmag;
          pneg  <= acc[63] ^ (!last && x_neg);
          prod  <= RND;
          mcnt  <= 3'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mcnt <= 3'd3) begin
            pp    <= mul_out;
            ppsel <= mcnt[1:0];
          end
          if (mcnt >= 3'd1) begin
            prod <= prod + pp_term;
          end
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd4) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (last) begin
            res_emf <= emf_clamp;
            res_oor <= 1'b0;
            state   <= S_DONE;
          end else begin
            acc   <= sum_sat;
            k     <= k - 4'd1;
            last  <= (k == 4'd1);
            state <= S_PREP;
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_emf   <= res_emf;
            out_oor   <= res_oor;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign sample.ready        = (state == S_IDLE);
  assign result.valid        = out_valid;
  assign result.emf_tenth_uv = out_emf;
  assign result.out_of_range = out_oor;

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.out_of_range |-> result.emf_tenth_uv == '0)
    else $error("out-of-range beat carries nonzero EMF");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample taken while previous one in flight");

  a_step_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && !last |-> k != 4'd0)
    else $error("Horner step index underflow");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && (!out_valid || result.ready) |=> out_valid && (state == S_IDLE))
    else $error("finished result not moved to output register");

endmodule

`default_nettype wire
